@@ sv/recursive_lock_table_top_assert.svh @@
// Assertion macros for the recursive lock table.
`ifndef RECURSIVE_LOCK_TABLE_TOP_ASSERT_SVH
`define RECURSIVE_LOCK_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RLT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RLT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/rlt_pkg.sv @@
// Types and constants shared by the recursive lock table modules.
`timescale 1ns / 1ps

package rlt_pkg;

   localparam int TABLE_SLOTS    = 16;
   localparam int SLOT_BITS      = 4;
   localparam int USED_BITS      = 5;
   localparam int THREAD_ID_BITS = 8;
   localparam int COUNT_BITS     = 16;
   localparam int KEY_BITS       = 32;
   localparam int SHIFT_BITS     = 2;

   localparam logic [SHIFT_BITS-1:0] HASH_SHIFT_RESET = 2'd2;

   typedef enum logic [1:0] {
      MODE_ENTER = 2'd0,
      MODE_EXIT  = 2'd1,
      MODE_WAIT  = 2'd2,
      MODE_CHECK = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_NEW       = 4'd0,
      ST_FREE      = 4'd1,
      ST_REENTER   = 4'd2,
      ST_BUSY      = 4'd3,
      ST_FULL      = 4'd4,
      ST_LIMIT     = 4'd5,
      ST_EXIT_OK   = 4'd6,
      ST_NOT_OWNER = 4'd7,
      ST_NOT_FOUND = 4'd8,
      ST_WAIT_OK   = 4'd9,
      ST_WAIT_NO   = 4'd10,
      ST_OWNER_OK  = 4'd11,
      ST_INVALID   = 4'd12
   } status_type;

   typedef struct packed {
      mode_type                  mode;
      logic [THREAD_ID_BITS-1:0] thread_id;
      logic [KEY_BITS-1:0]       object_ref;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [COUNT_BITS-1:0] hold_count;
      logic [SLOT_BITS-1:0]  slot_index;
   } rsp_type;

   // One table entry: key 0 means empty, owner 0 means unowned.
   typedef struct packed {
      logic [KEY_BITS-1:0]       key;
      logic [THREAD_ID_BITS-1:0] owner;
      logic [COUNT_BITS-1:0]     count;
   } entry_type;

   // Outcome of one lock operation on the probed entry.
   typedef struct packed {
      status_type status;
      entry_type  entry;
      logic       wr_en;
      logic       has_entry;
   } lock_op_type;

endpackage

@@ sv/rlt_lock_alu.sv @@
// Lock operation logic: decides status and updated entry for one request.
`timescale 1ns / 1ps

module rlt_lock_alu (
   input  rlt_pkg::mode_type                           mode,
   input  logic [rlt_pkg::THREAD_ID_BITS-1:0]          thread_id,
   input  logic [rlt_pkg::KEY_BITS-1:0]                object_ref,
   input  logic                                        hit,
   input  logic                                        table_full,
   input  rlt_pkg::entry_type                          entry_rd,
   output rlt_pkg::lock_op_type                        op
);

   logic owner_match;
   logic count_max;
   logic count_le1;
   logic count_one;

   assign owner_match = (entry_rd.owner == thread_id);
   assign count_max   = &entry_rd.count;
   assign count_one   = (entry_rd.count == rlt_pkg::COUNT_BITS'(1));
   assign count_le1   = (entry_rd.count <= rlt_pkg::COUNT_BITS'(1));

   always_comb begin
      op.status    = rlt_pkg::ST_NOT_FOUND;
      op.entry     = entry_rd;
      op.wr_en     = 1'b0;
      op.has_entry = hit;

      if (!hit) begin
         // Absent key: insert on enter if a slot is left
         if (mode == rlt_pkg::MODE_ENTER && !table_full) begin
            op.entry.key   = object_ref;
            op.entry.owner = thread_id;
            op.entry.count = rlt_pkg::COUNT_BITS'(1);
            op.wr_en       = 1'b1;
            op.has_entry   = 1'b1;
            op.status      = rlt_pkg::ST_NEW;
         end else if (mode == rlt_pkg::MODE_ENTER) begin
            op.status = rlt_pkg::ST_FULL;
         end else begin
            op.status = rlt_pkg::ST_NOT_FOUND;
         end
      end else begin
         unique case (mode)
            rlt_pkg::MODE_ENTER: begin
               priority if (entry_rd.owner == '0) begin
                  op.entry.owner = thread_id;
                  op.entry.count = rlt_pkg::COUNT_BITS'(1);
                  op.wr_en       = 1'b1;
                  op.status      = rlt_pkg::ST_FREE;
               end else if (owner_match && count_max) begin
                  op.status = rlt_pkg::ST_LIMIT;
               end else if (owner_match) begin
                  op.entry.count = entry_rd.count + rlt_pkg::COUNT_BITS'(1);
                  op.wr_en       = 1'b1;
                  op.status      = rlt_pkg::ST_REENTER;
               end else begin
                  op.status = rlt_pkg::ST_BUSY;
               end
            end
            rlt_pkg::MODE_EXIT: begin
               if (owner_match) begin
                  if (count_le1) begin
                     op.entry.owner = '0;
                     op.entry.count = '0;
                  end else begin
                     op.entry.count = entry_rd.count - rlt_pkg::COUNT_BITS'(1);
                  end
                  op.wr_en  = 1'b1;
                  op.status = rlt_pkg::ST_EXIT_OK;
               end else begin
                  op.status = rlt_pkg::ST_NOT_OWNER;
               end
            end
            rlt_pkg::MODE_WAIT: begin
               if (owner_match && count_one) begin
                  op.entry.owner = '0;
                  op.entry.count = '0;
                  op.wr_en       = 1'b1;
                  op.status      = rlt_pkg::ST_WAIT_OK;
               end else begin
                  op.status = rlt_pkg::ST_WAIT_NO;
               end
            end
            rlt_pkg::MODE_CHECK: begin
               op.status = owner_match ? rlt_pkg::ST_OWNER_OK : rlt_pkg::ST_NOT_OWNER;
            end
            default: begin
               op.status = rlt_pkg::ST_NOT_FOUND;
            end
         endcase
      end
   end

endmodule

@@ sv/recursive_lock_table_top.sv @@
// Recursive lock table: top level with entry memory and probe sequencer.
`timescale 1ns / 1ps

// A table of 16 recursive locks keyed by object reference, held in one
// synchronous entry memory (key, owner, hold count) with a valid bit per
// slot so that reset empties the table at once. Each request probes
// linearly from its home slot ((object_ref >> hash_shift) mod 16), one
// memory read per cycle, until it finds the key, an empty slot, or has
// seen all 16 slots. The first read goes out with acceptance, each probed
// slot is checked from the registered read port, and the result passes
// through the result register into the output register. Requests with a
// zero reference or thread skip the probe and go straight to the output
// stage. The block takes one request at a time; the next request can be
// accepted once the previous result is loaded into the output register. A finished result may
// wait in the output register while the next request is accepted.
// hash_shift is written through the csr port; the user must write it only
// while no request is in flight, as the block itself does not enforce it.

`include "recursive_lock_table_top_assert.svh"

module recursive_lock_table_top (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  rlt_pkg::req_type                   req_data,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output rlt_pkg::rsp_type                   rsp_data,
   // configuration
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rlt_pkg::SHIFT_BITS-1:0]     csr_data
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_PROBE = 3'b010,
      S_DONE  = 3'b100
   } state_type;

   state_type                           state_ff, state_in;
   rlt_pkg::req_type                    req_ff, req_in;
   logic [rlt_pkg::SLOT_BITS-1:0]       slot_ff, slot_in;
   logic [rlt_pkg::SLOT_BITS-1:0]       probe_cnt_ff, probe_cnt_in;
   logic [rlt_pkg::USED_BITS-1:0]       used_ff, used_in;
   logic [rlt_pkg::SHIFT_BITS-1:0]      shift_ff;
   logic [rlt_pkg::TABLE_SLOTS-1:0]     valid_ff;
   rlt_pkg::rsp_type                    res_ff, res_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   rlt_pkg::rsp_type                    rsp_data_ff;

   // entry memory and its registered read port
   rlt_pkg::entry_type                  mem [rlt_pkg::TABLE_SLOTS];
   rlt_pkg::entry_type                  rd_entry_ff;
   logic                                rd_valid_ff;
   logic [rlt_pkg::SLOT_BITS-1:0]       rd_addr;
   logic                                mem_we;

   logic                                req_accept;
   logic                                req_invalid;
   logic [rlt_pkg::KEY_BITS-1:0]        shifted_ref;
   logic [rlt_pkg::SLOT_BITS-1:0]       home_slot;
   rlt_pkg::entry_type                  entry_view;
   logic                                hit;
   logic                                empty;
   logic                                last_probe;
   logic                                probe_done;
   logic                                table_full;
   logic                                rsp_load;
   rlt_pkg::lock_op_type                op;

   // handshakes
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // home slot of an incoming request
   assign req_invalid = (req_data.object_ref == '0) || (req_data.thread_id == '0);
   assign shifted_ref = req_data.object_ref >> shift_ff;
   assign home_slot   = shifted_ref[rlt_pkg::SLOT_BITS-1:0];

   // probed entry; a slot never written reads as empty
   assign entry_view = rd_valid_ff ? rd_entry_ff : '0;
   assign hit        = (entry_view.key == req_ff.object_ref);
   assign empty      = (entry_view.key == '0);
   assign last_probe = (probe_cnt_ff == rlt_pkg::SLOT_BITS'(rlt_pkg::TABLE_SLOTS - 1));
   assign probe_done = hit || empty || last_probe;
   assign table_full = !empty ||
                       (used_ff >= rlt_pkg::USED_BITS'(rlt_pkg::TABLE_SLOTS));

   rlt_lock_alu u_alu (
      .mode       (req_ff.mode),
      .thread_id  (req_ff.thread_id),
      .object_ref (req_ff.object_ref),
      .hit        (hit),
      .table_full (table_full),
      .entry_rd   (entry_view),
      .op         (op)
   );

   // write-back ends the probe; the next read comes after the output
   // stage, so a read never overlaps a pending write to the same slot
   assign mem_we   = (state_ff == S_PROBE) && probe_done && op.wr_en;
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      slot_in      = slot_ff;
      probe_cnt_in = probe_cnt_ff;
      used_in      = used_ff;
      res_in       = res_ff;
      rd_addr      = slot_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               req_in       = req_data;
               slot_in      = home_slot;
               probe_cnt_in = '0;
               rd_addr      = home_slot;
               if (req_invalid) begin
                  res_in.status     = rlt_pkg::ST_INVALID;
                  res_in.hold_count = '0;
                  res_in.slot_index = '0;
                  state_in          = S_DONE;
               end else begin
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (probe_done) begin
               res_in.status     = op.status;
               res_in.hold_count = op.has_entry ? op.entry.count : '0;
               res_in.slot_index = op.has_entry ? slot_ff : '0;
               if (op.status == rlt_pkg::ST_NEW) begin
                  used_in = used_ff + rlt_pkg::USED_BITS'(1);
               end
               state_in = S_DONE;
            end else begin
               slot_in      = slot_ff + rlt_pkg::SLOT_BITS'(1);
               probe_cnt_in = probe_cnt_ff + rlt_pkg::SLOT_BITS'(1);
               rd_addr      = slot_ff + rlt_pkg::SLOT_BITS'(1);
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         shift_ff     <= rlt_pkg::HASH_SHIFT_RESET;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= valid_ff[rd_addr];
         if (csr_valid && csr_ready) begin
            shift_ff <= csr_data;
         end
         if (mem_we) begin
            valid_ff[slot_ff] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      slot_ff      <= slot_in;
      probe_cnt_ff <= probe_cnt_in;
      res_ff       <= res_in;
      if (rsp_load) begin
         rsp_data_ff <= res_ff;
      end
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[slot_ff] <= op.entry;
      end
      rd_entry_ff <= mem[rd_addr];
   end

   // checks
   `RLT_ASSERT_NOW(a_used_bound, clock, reset, 1'b1,
      used_ff <= rlt_pkg::USED_BITS'(rlt_pkg::TABLE_SLOTS), "used entry count overflow")
   `RLT_ASSERT_NOW(a_no_zero_key, clock, reset, mem_we,
      op.entry.key == req_ff.object_ref && op.entry.key != '0, "bad key written to table")
   `RLT_ASSERT_NEXT(a_insert_counts, clock, reset,
      mem_we && op.status == rlt_pkg::ST_NEW,
      used_ff == $past(used_ff) + rlt_pkg::USED_BITS'(1), "insert not counted")
   `RLT_ASSERT_NEXT(a_load_idle, clock, reset, rsp_load,
      state_ff == S_IDLE && rsp_valid_ff, "result beat without return to idle")

endmodule

@@ bench/lock_table_checker.sv @@
// Checker for the recursive lock table: predicts each request's result and compares.
`timescale 1ns / 1ps

module lock_table_checker
   import rlt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [SHIFT_BITS-1:0] csr_data,
   output int                    failures,
   output int                    pending
);

   // Local copy of the lock table and its configuration
   logic [KEY_BITS-1:0]       key_mem   [TABLE_SLOTS];
   logic [THREAD_ID_BITS-1:0] owner_mem [TABLE_SLOTS];
   logic [COUNT_BITS-1:0]     count_mem [TABLE_SLOTS];
   int unsigned               used_slots;
   logic [SHIFT_BITS-1:0]     hash_shift;

   rsp_type results_due [$];
   int      error_total = 0;

   initial begin
      failures = 0;
      pending  = 0;
   end

   // Apply one lock request to the local table and return the result beat it owes.
   function automatic rsp_type apply_lock_op(input req_type r);
      rsp_type                   res;
      logic [SLOT_BITS-1:0]      idx;
      logic [SLOT_BITS-1:0]      slot;
      logic [SLOT_BITS-1:0]      empty_slot;
      logic                      hit;
      logic                      have_empty;
      logic [THREAD_ID_BITS-1:0] own;
      int                        n;
      res.status     = ST_INVALID;
      res.hold_count = '0;
      res.slot_index = '0;
      hit            = 1'b0;
      have_empty     = 1'b0;
      slot           = '0;
      empty_slot     = '0;
      if (r.object_ref == '0 || r.thread_id == '0) begin
         return res;
      end

      // linear probe from the home slot, stop at a match or the first empty slot
      idx = SLOT_BITS'(r.object_ref >> hash_shift);
      for (n = 0; n < TABLE_SLOTS; n++) begin
         if (!hit && !have_empty) begin
            if (key_mem[idx] == r.object_ref) begin
               hit  = 1'b1;
               slot = idx;
            end else if (key_mem[idx] == '0) begin
               have_empty = 1'b1;
               empty_slot = idx;
            end
            idx = idx + 1'b1;
         end
      end

      if (!hit) begin
         if (r.mode != MODE_ENTER) begin
            res.status = ST_NOT_FOUND;
         end else if (!have_empty || used_slots >= TABLE_SLOTS) begin
            res.status = ST_FULL;
         end else begin
            key_mem[empty_slot]   = r.object_ref;
            owner_mem[empty_slot] = r.thread_id;
            count_mem[empty_slot] = 1;
            used_slots++;
            res.status     = ST_NEW;
            res.hold_count = 1;
            res.slot_index = empty_slot;
         end
         return res;
      end

      own = owner_mem[slot];
      case (r.mode)
         MODE_ENTER: begin
            if (own == '0) begin
               owner_mem[slot] = r.thread_id;
               count_mem[slot] = 1;
               res.status      = ST_FREE;
            end else if (own == r.thread_id) begin
               if (count_mem[slot] == '1) begin
                  res.status = ST_LIMIT;
               end else begin
                  count_mem[slot] = count_mem[slot] + 1'b1;
                  res.status      = ST_REENTER;
               end
            end else begin
               res.status = ST_BUSY;
            end
         end
         MODE_EXIT: begin
            if (own == r.thread_id) begin
               if (count_mem[slot] <= 1) begin
                  count_mem[slot] = '0;
                  owner_mem[slot] = '0;
               end else begin
                  count_mem[slot] = count_mem[slot] - 1'b1;
               end
               res.status = ST_EXIT_OK;
            end else begin
               res.status = ST_NOT_OWNER;
            end
         end
         MODE_WAIT: begin
            if (own == r.thread_id && count_mem[slot] == 1) begin
               owner_mem[slot] = '0;
               count_mem[slot] = '0;
               res.status      = ST_WAIT_OK;
            end else begin
               res.status = ST_WAIT_NO;
            end
         end
         default: begin
            res.status = (own == r.thread_id) ? ST_OWNER_OK : ST_NOT_OWNER;
         end
      endcase
      res.hold_count = count_mem[slot];
      res.slot_index = slot;
      return res;
   endfunction

   // Watch the three channels; results are checked before the same edge's request
   always @(posedge clock) begin : monitor
      rsp_type want;
      int      i;
      if (reset) begin
         for (i = 0; i < TABLE_SLOTS; i++) begin
            key_mem[i]   = '0;
            owner_mem[i] = '0;
            count_mem[i] = '0;
         end
         used_slots = 0;
         hash_shift = HASH_SHIFT_RESET;
         results_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            hash_shift = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               $error("result beat with no request outstanding");
               error_total++;
            end else begin
               want = results_due.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  error_total++;
               end
               if (rsp_data.hold_count !== want.hold_count) begin
                  $error("hold_count: expected %0d, got %0d",
                         want.hold_count, rsp_data.hold_count);
                  error_total++;
               end
               if (rsp_data.slot_index !== want.slot_index) begin
                  $error("slot_index: expected %0d, got %0d",
                         want.slot_index, rsp_data.slot_index);
                  error_total++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            results_due.push_back(apply_lock_op(req_data));
         end
      end
      failures <= error_total;
      pending  <= results_due.size();
   end

endmodule

@@ bench/testbench.sv @@
// Top of the recursive lock table bench: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps

module testbench;
   import rlt_pkg::*;

   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES      = 40;
   localparam int PHASE_ITEMS      = 384;
   localparam int PHASES           = 5;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [SHIFT_BITS-1:0] csr_data;

   int error_count;
   int results_left;
   int items_sent = 0;
   int idle_cycles = 0;

   // quiet: no idling on either side; long_hold: receiver holds off for a long stretch
   bit quiet     = 1'b0;
   bit long_hold = 1'b0;

   logic [KEY_BITS-1:0]       lock_keys  [TABLE_SLOTS];
   logic [THREAD_ID_BITS-1:0] thread_ids [4];
   logic [SHIFT_BITS-1:0]     shift_plan [PHASES] = '{2'd0, 2'd3, 2'd1, 2'd3, 2'd2};

   recursive_lock_table_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   lock_table_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .failures  (error_count),
      .pending   (results_left)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: too long without any beat on any channel ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold = 1'b0;
         end else if (!quiet && $urandom_range(4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic req_type make_req(input mode_type m,
                                        input logic [THREAD_ID_BITS-1:0] t,
                                        input logic [KEY_BITS-1:0] k);
      req_type r;
      r.mode       = m;
      r.thread_id  = t;
      r.object_ref = k;
      return r;
   endfunction

   // Offer one request beat and hold it until taken; sometimes idle afterwards
   task automatic offer(input req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (!quiet && $urandom_range(3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic wait_drained;
      req_valid <= 1'b0;
      do @(posedge clock); while (results_left != 0);
   endtask

   task automatic write_hash_shift(input logic [SHIFT_BITS-1:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // One lock episode on a known key, or a noise beat
   task automatic run_episode;
      logic [KEY_BITS-1:0]       key;
      logic [THREAD_ID_BITS-1:0] tid;
      logic [THREAD_ID_BITS-1:0] rival;
      req_type                   r;
      int                        depth;
      int                        pick;
      key   = lock_keys[$urandom_range(TABLE_SLOTS - 1)];
      tid   = thread_ids[$urandom_range(3)];
      rival = thread_ids[$urandom_range(3)];
      depth = $urandom_range(1, 3);
      pick  = $urandom_range(9);
      if (pick < 7) begin
         repeat (depth) offer(make_req(MODE_ENTER, tid, key));
         if ($urandom_range(1)) offer(make_req(MODE_CHECK, tid, key));
         if ($urandom_range(2) == 0) offer(make_req(mode_type'($urandom_range(3)), rival, key));
         if (depth == 1 && $urandom_range(1)) begin
            // hand the lock over through a wait release
            offer(make_req(MODE_WAIT, tid, key));
            if ($urandom_range(1)) begin
               offer(make_req(MODE_ENTER, rival, key));
               offer(make_req(MODE_EXIT, rival, key));
            end
         end else begin
            repeat (depth) offer(make_req(MODE_EXIT, tid, key));
         end
      end else if (pick == 7) begin
         // zero thread or zero reference
         r = make_req(mode_type'($urandom_range(3)), THREAD_ID_BITS'($urandom_range(255)),
                      $urandom());
         if ($urandom_range(1)) r.thread_id = '0;
         else r.object_ref = '0;
         offer(r);
      end else if (pick == 8) begin
         // unknown reference: full table or not found
         offer(make_req(mode_type'($urandom_range(3)), THREAD_ID_BITS'($urandom_range(1, 255)),
                        $urandom()));
      end else begin
         offer(make_req(mode_type'($urandom_range(3)), tid, key));
      end
   endtask

   initial begin : stimulus
      logic [KEY_BITS-1:0] fresh;
      int                  i;
      int                  p;
      int                  start;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;

      // distinct nonzero keys, with both extremes of the reference
      for (i = 0; i < TABLE_SLOTS - 2; i++) begin
         lock_keys[i]        = $urandom();
         lock_keys[i][27:24] = 4'(i + 1);
      end
      lock_keys[TABLE_SLOTS - 2] = 32'h0000_0001;
      lock_keys[TABLE_SLOTS - 1] = 32'hFFFF_FFFF;
      fresh        = $urandom();
      fresh[27:24] = 4'hF;
      fresh[0]     = 1'b0;
      thread_ids[0] = 8'd1;
      thread_ids[1] = 8'd255;
      thread_ids[2] = THREAD_ID_BITS'($urandom_range(2, 254));
      thread_ids[3] = THREAD_ID_BITS'($urandom_range(2, 254));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: invalid inputs, fill the table, full and not found, then all but the limit on one key
      offer(make_req(MODE_ENTER, 8'd0, lock_keys[0]));
      offer(make_req(MODE_CHECK, 8'd255, 32'd0));
      for (i = 0; i < TABLE_SLOTS; i++) begin
         offer(make_req(MODE_ENTER, thread_ids[i % 4], lock_keys[i]));
      end
      offer(make_req(MODE_ENTER, thread_ids[0], fresh));
      offer(make_req(MODE_EXIT, thread_ids[1], fresh));
      offer(make_req(MODE_ENTER, thread_ids[0], lock_keys[0]));
      offer(make_req(MODE_ENTER, thread_ids[1], lock_keys[0]));
      offer(make_req(MODE_EXIT, thread_ids[1], lock_keys[0]));
      offer(make_req(MODE_CHECK, thread_ids[0], lock_keys[0]));
      offer(make_req(MODE_CHECK, thread_ids[1], lock_keys[0]));
      offer(make_req(MODE_WAIT, thread_ids[0], lock_keys[0]));
      offer(make_req(MODE_EXIT, thread_ids[0], lock_keys[0]));
      offer(make_req(MODE_WAIT, thread_ids[0], lock_keys[0]));
      offer(make_req(MODE_ENTER, thread_ids[2], lock_keys[0]));

      // reenter, exit and a refused wait release on one key; it stays held afterwards
      quiet = 1'b1;
      offer(make_req(MODE_ENTER, thread_ids[2], lock_keys[0]));
      offer(make_req(MODE_ENTER, thread_ids[2], lock_keys[0]));
      offer(make_req(MODE_EXIT, thread_ids[2], lock_keys[0]));
      offer(make_req(MODE_ENTER, thread_ids[2], lock_keys[0]));
      offer(make_req(MODE_WAIT, thread_ids[2], lock_keys[0]));
      quiet = 1'b0;

      // random phases, each after writing its hash shift from the plan; last phase runs without idling
      for (p = 0; p < PHASES; p++) begin
         wait_drained();
         write_hash_shift(shift_plan[p]);
         if (p == 1) long_hold = 1'b1;
         if (p == PHASES - 1) quiet = 1'b1;
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) run_episode();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
